@@ hdl/lmsso_pkg.sv @@
// Shared constants and types for the LED matrix scan driver with sprite overlay.
`default_nettype none
package lmsso_pkg;

	// Default matrix geometry
	localparam int LMSSO_ROWS        = 16;
	localparam int LMSSO_COLUMNS     = 8;
	localparam int LMSSO_SPRITE_ROWS = 4;

	localparam int KIND_W = 3;

	// Item kinds; codes five to seven carry no meaning and are dropped
	typedef enum logic [KIND_W-1:0] {
		KIND_TICK      = 3'd0,
		KIND_WR_PIXEL  = 3'd1,
		KIND_TGL_PIXEL = 3'd2,
		KIND_WR_SPRITE = 3'd3,
		KIND_SET_POS   = 3'd4
	} kind_t;

	// Decoded state-update strobes for one transaction
	typedef struct packed {
		logic wr_pixel;
		logic tgl_pixel;
		logic wr_sprite;
		logic set_pos;
	} cmd_t;

endpackage
`default_nettype wire

@@ hdl/lmsso_frame.sv @@
// Frame store: pixel set, clear and toggle, and column readout for the scan.
`default_nettype none
module lmsso_frame #(
	parameter int ROWS    = lmsso_pkg::LMSSO_ROWS,
	parameter int COLUMNS = lmsso_pkg::LMSSO_COLUMNS
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire lmsso_pkg::cmd_t            cmd,
	input  wire logic [$clog2(COLUMNS)-1:0] pixel_col,
	input  wire logic [$clog2(ROWS)-1:0]    pixel_row,
	input  wire logic                       pixel_on,
	input  wire logic [$clog2(COLUMNS)-1:0] scan_col,
	output logic      [ROWS-1:0]            col_bits
);

	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLUMNS);
	localparam logic [RW:0] ROWS_C = (RW+1)'(ROWS);
	localparam logic [CW:0] COLS_C = (CW+1)'(COLUMNS);

	logic [COLUMNS-1:0] frame_q [ROWS];
	logic               hit;

	// Drop pixels that fall outside the matrix
	assign hit = ({1'b0, pixel_row} < ROWS_C) && ({1'b0, pixel_col} < COLS_C);

	// Update one pixel per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				frame_q[r] <= '0;
			end
		end else if (hit) begin
			if (cmd.tgl_pixel) begin
				frame_q[pixel_row][pixel_col] <= ~frame_q[pixel_row][pixel_col];
			end else if (cmd.wr_pixel) begin
				frame_q[pixel_row][pixel_col] <= pixel_on;
			end
		end
	end

	// Read the selected column out of every row
	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			col_bits[r] = frame_q[r][scan_col];
		end
	end

endmodule
`default_nettype wire

@@ hdl/lmsso_sprite.sv @@
// Sprite store and position, and the sprite overlay for the scanned column.
`default_nettype none
module lmsso_sprite #(
	parameter int ROWS        = lmsso_pkg::LMSSO_ROWS,
	parameter int COLUMNS     = lmsso_pkg::LMSSO_COLUMNS,
	parameter int SPRITE_ROWS = lmsso_pkg::LMSSO_SPRITE_ROWS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire lmsso_pkg::cmd_t                       cmd,
	input  wire logic [((SPRITE_ROWS > 1) ? $clog2(SPRITE_ROWS) : 1)-1:0] sprite_index,
	input  wire logic [COLUMNS-1:0]                    sprite_bits,
	input  wire logic [$clog2(ROWS+SPRITE_ROWS)-1:0]   sprite_bottom,
	input  wire logic [$clog2(COLUMNS)-1:0]            scan_col,
	output logic      [ROWS-1:0]                       overlay
);

	localparam int SW = (SPRITE_ROWS > 1) ? $clog2(SPRITE_ROWS) : 1;
	localparam int PW = $clog2(ROWS + SPRITE_ROWS);
	localparam logic [SW:0] SROWS_C = (SW+1)'(SPRITE_ROWS);

	logic [COLUMNS-1:0] sprite_q [SPRITE_ROWS];
	logic [PW-1:0]      pos_q;

	// Hold sprite rows and bottom position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SPRITE_ROWS; k++) begin
				sprite_q[k] <= '0;
			end
			pos_q <= '0;
		end else begin
			if (cmd.wr_sprite && ({1'b0, sprite_index} < SROWS_C)) begin
				sprite_q[sprite_index] <= sprite_bits;
			end
			if (cmd.set_pos) begin
				pos_q <= sprite_bottom;
			end
		end
	end

	// Row i is covered when pos-SPRITE_ROWS <= i < pos, by sprite row i+SPRITE_ROWS-pos
	for (genvar i = 0; i < ROWS; i++) begin : g_row
		localparam logic [PW-1:0] ROW_C = PW'(i);
		localparam logic [PW-1:0] TOP_C = PW'(i + SPRITE_ROWS);
		logic          covered;
		logic [PW-1:0] diff;
		logic [SW-1:0] k;

		assign covered     = (pos_q > ROW_C) && (pos_q <= TOP_C);
		assign diff        = TOP_C - pos_q;
		assign k           = diff[SW-1:0];
		assign overlay[i]  = covered && sprite_q[k][scan_col];
	end

endmodule
`default_nettype wire

@@ hdl/led_matrix_scan_with_sprite_overlay.sv @@
// Top level: input stage, scan column counter and line drive result register.
// A tick passes through the input stage and then the result register before it shows on out_valid.
// Throughput: one transaction per cycle of any kind while the result side does not stall;
// a tick waits in the input stage only while the result register holds an untaken result.
// Write kinds update state in the cycle after acceptance and give no result.
// Reset (arst_n low) clears frame, sprite, sprite position, scan column and all valid flags.
`default_nettype none
module led_matrix_scan_with_sprite_overlay #(
	parameter int ROWS        = lmsso_pkg::LMSSO_ROWS,
	parameter int COLUMNS     = lmsso_pkg::LMSSO_COLUMNS,
	parameter int SPRITE_ROWS = lmsso_pkg::LMSSO_SPRITE_ROWS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [lmsso_pkg::KIND_W-1:0]          kind,
	input  wire logic [$clog2(COLUMNS)-1:0]            pixel_col,
	input  wire logic [$clog2(ROWS)-1:0]               pixel_row,
	input  wire logic                                  pixel_on,
	input  wire logic [((SPRITE_ROWS > 1) ? $clog2(SPRITE_ROWS) : 1)-1:0] sprite_index,
	input  wire logic [COLUMNS-1:0]                    sprite_bits,
	input  wire logic [$clog2(ROWS+SPRITE_ROWS)-1:0]   sprite_bottom,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic      [COLUMNS-1:0]                    scan_select,
	output logic      [ROWS-1:0]                       line_drive
);

	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLUMNS);
	localparam int SW = (SPRITE_ROWS > 1) ? $clog2(SPRITE_ROWS) : 1;
	localparam int PW = $clog2(ROWS + SPRITE_ROWS);
	localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);

	// Input stage
	logic                          valid_s1;
	logic [lmsso_pkg::KIND_W-1:0]  kind_s1;
	logic [CW-1:0]                 pixel_col_s1;
	logic [RW-1:0]                 pixel_row_s1;
	logic                          pixel_on_s1;
	logic [SW-1:0]                 sprite_index_s1;
	logic [COLUMNS-1:0]            sprite_bits_s1;
	logic [PW-1:0]                 sprite_bottom_s1;

	logic                          is_tick;
	lmsso_pkg::cmd_t               dec;
	lmsso_pkg::cmd_t               cmd;
	logic                          advance;

	logic [CW-1:0]                 scan_col_q;
	logic [ROWS-1:0]               col_bits;
	logic [ROWS-1:0]               overlay;

	logic                          out_valid_q;
	logic [COLUMNS-1:0]            scan_select_q;
	logic [ROWS-1:0]               line_drive_q;

	// Decode the staged kind
	always_comb begin
		dec     = '0;
		is_tick = 1'b0;
		case (lmsso_pkg::kind_t'(kind_s1))
			lmsso_pkg::KIND_TICK:      is_tick       = 1'b1;
			lmsso_pkg::KIND_WR_PIXEL:  dec.wr_pixel  = 1'b1;
			lmsso_pkg::KIND_TGL_PIXEL: dec.tgl_pixel = 1'b1;
			lmsso_pkg::KIND_WR_SPRITE: dec.wr_sprite = 1'b1;
			lmsso_pkg::KIND_SET_POS:   dec.set_pos   = 1'b1;
			default: begin
				dec     = '0;
				is_tick = 1'b0;
			end
		endcase
	end

	// Retire the staged transaction unless a tick finds the result register blocked
	assign advance  = valid_s1 && (!is_tick || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign cmd      = advance ? dec : '0;

	// Load the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1          <= kind;
			pixel_col_s1     <= pixel_col;
			pixel_row_s1     <= pixel_row;
			pixel_on_s1      <= pixel_on;
			sprite_index_s1  <= sprite_index;
			sprite_bits_s1   <= sprite_bits;
			sprite_bottom_s1 <= sprite_bottom;
		end
	end

	lmsso_frame #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.pixel_col (pixel_col_s1),
		.pixel_row (pixel_row_s1),
		.pixel_on  (pixel_on_s1),
		.scan_col  (scan_col_q),
		.col_bits  (col_bits)
	);

	lmsso_sprite #(
		.ROWS        (ROWS),
		.COLUMNS     (COLUMNS),
		.SPRITE_ROWS (SPRITE_ROWS)
	) u_sprite (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sprite_index  (sprite_index_s1),
		.sprite_bits   (sprite_bits_s1),
		.sprite_bottom (sprite_bottom_s1),
		.scan_col      (scan_col_q),
		.overlay       (overlay)
	);

	// Advance the scan column on each retired tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_col_q <= '0;
		end else if (advance && is_tick) begin
			scan_col_q <= (scan_col_q == LAST_COL) ? '0 : scan_col_q + 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_tick) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_tick) begin
			scan_select_q <= COLUMNS'(1) << scan_col_q;
			line_drive_q  <= col_bits | overlay;
		end
	end

	assign out_valid   = out_valid_q;
	assign scan_select = scan_select_q;
	assign line_drive  = line_drive_q;

`ifndef SYNTHESIS
	localparam logic [CW:0] COLS_C = (CW+1)'(COLUMNS);

	a_select_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot(scan_select_q))
		else $error("scan select is not one-hot");

	a_tick_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_tick) |=> out_valid_q)
		else $error("retired tick did not load a result");

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with empty input stage");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, scan_col_q} < COLS_C))
		else $error("scan column out of range");

	a_write_keeps_col: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !is_tick) |=> $stable(scan_col_q))
		else $error("scan column moved on a write transaction");
`endif

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the LED matrix scan driver with sprite overlay.
module tb_top;
	import lmsso_pkg::*;

	localparam int ROWS        = LMSSO_ROWS;
	localparam int COLUMNS     = LMSSO_COLUMNS;
	localparam int SPRITE_ROWS = LMSSO_SPRITE_ROWS;
	localparam int COL_W       = $clog2(COLUMNS);
	localparam int ROW_W       = $clog2(ROWS);
	localparam int IDX_W       = (SPRITE_ROWS > 1) ? $clog2(SPRITE_ROWS) : 1;
	localparam int POS_W       = $clog2(ROWS + SPRITE_ROWS);

	localparam logic [KIND_W-1:0] FIRST_UNUSED_KIND = KIND_W'(KIND_SET_POS + 1);

	localparam int RANDOM_ITEMS = 500;
	localparam int HOLD_CYCLES  = 60;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_REPORTS  = 10;

	// One input transaction, all fields
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic              on;
		logic [IDX_W-1:0]  idx;
		logic [COLUMNS-1:0] bits;
		logic [POS_W-1:0]  bottom;
	} item_t;

	localparam int ITEM_W = $bits(item_t);

	// One scan step as seen on the result side
	typedef struct packed {
		logic [COLUMNS-1:0] sel;
		logic [ROWS-1:0]    drive;
	} scan_t;

	// Tracks frame, sprite and scan column; predicts and checks each scan step
	class scan_scoreboard;
		logic [COLUMNS-1:0] frame_rows [ROWS];
		logic [COLUMNS-1:0] sprite_rows [SPRITE_ROWS];
		int                 bottom_row;
		int                 column;
		scan_t              pending_scans [$];
		int                 errors;

		function new();
			foreach (frame_rows[i]) frame_rows[i] = '0;
			foreach (sprite_rows[i]) sprite_rows[i] = '0;
			bottom_row = 0;
			column = 0;
			errors = 0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= MAX_REPORTS) begin
				$display("ERROR: %s", msg);
			end
		endfunction

		// Apply an accepted transaction; a tick queues the expected scan step
		function void note_transaction(item_t it);
			scan_t s;
			int k;
			case (it.kind)
				KIND_TICK: begin
					s.sel = '0;
					s.sel[column] = 1'b1;
					s.drive = '0;
					for (int r = 0; r < ROWS; r++) begin
						s.drive[r] = frame_rows[r][column];
						// sprite row k covers matrix row bottom-SPRITE_ROWS+k
						k = r + SPRITE_ROWS - bottom_row;
						if (k >= 0 && k < SPRITE_ROWS && sprite_rows[k][column]) begin
							s.drive[r] = 1'b1;
						end
					end
					pending_scans.push_back(s);
					column = (column + 1) % COLUMNS;
				end
				KIND_WR_PIXEL: begin
					frame_rows[it.row][it.col] = it.on;
				end
				KIND_TGL_PIXEL: begin
					frame_rows[it.row][it.col] = ~frame_rows[it.row][it.col];
				end
				KIND_WR_SPRITE: begin
					if (it.idx < SPRITE_ROWS) begin
						sprite_rows[it.idx] = it.bits;
					end
				end
				KIND_SET_POS: begin
					bottom_row = it.bottom;
				end
				default: begin
				end
			endcase
		endfunction

		// Compare a result transaction against the oldest expected scan step
		function void check_scan(logic [COLUMNS-1:0] sel, logic [ROWS-1:0] drive);
			scan_t want;
			if (pending_scans.size() == 0) begin
				flag($sformatf("scan result with none expected: select %h drive %h",
					sel, drive));
				return;
			end
			want = pending_scans.pop_front();
			if (sel !== want.sel) begin
				flag($sformatf("scan_select expected %h actual %h", want.sel, sel));
			end
			if (drive !== want.drive) begin
				flag($sformatf("line_drive expected %h actual %h (select %h)",
					want.drive, drive, want.sel));
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_stall;
	logic [KIND_W-1:0]  kind         = '0;
	logic [COL_W-1:0]   pixel_col    = '0;
	logic [ROW_W-1:0]   pixel_row    = '0;
	logic               pixel_on     = 1'b0;
	logic [IDX_W-1:0]   sprite_index = '0;
	logic [COLUMNS-1:0] sprite_bits  = '0;
	logic [POS_W-1:0]   sprite_bottom = '0;
	logic               out_valid;
	logic               out_stall    = 1'b0;
	logic [COLUMNS-1:0] scan_select;
	logic [ROWS-1:0]    line_drive;

	logic steady    = 1'b0;
	logic hold_req  = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;
	int   cycle_count = 0;

	scan_scoreboard sb;

	led_matrix_scan_with_sprite_overlay i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.pixel_col     (pixel_col),
		.pixel_row     (pixel_row),
		.pixel_on      (pixel_on),
		.sprite_index  (sprite_index),
		.sprite_bits   (sprite_bits),
		.sprite_bottom (sprite_bottom),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.scan_select   (scan_select),
		.line_drive    (line_drive)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result side: random stalls, one long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_stall <= !steady && ($urandom_range(99) < 28);
		end
	end

	// Check every result transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_scan(scan_select, line_drive);
		end
	end

	function automatic item_t noise_item(input logic [KIND_W-1:0] k);
		item_t it;
		it = item_t'(ITEM_W'($urandom));
		it.kind = k;
		return it;
	endfunction

	// Offer one transaction after a random gap; hold it until accepted
	task automatic send_item(input item_t it);
		while (!steady && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		kind          <= it.kind;
		pixel_col     <= it.col;
		pixel_row     <= it.row;
		pixel_on      <= it.on;
		sprite_index  <= it.idx;
		sprite_bits   <= it.bits;
		sprite_bottom <= it.bottom;
		do @(posedge clk); while (in_stall);
		sb.note_transaction(it);
	endtask

	task automatic send_tick();
		send_item(noise_item(KIND_TICK));
	endtask

	task automatic send_pixel(input logic [KIND_W-1:0] k, input int col, input int row,
			input bit on);
		item_t it;
		it = noise_item(k);
		it.col = COL_W'(col);
		it.row = ROW_W'(row);
		it.on  = on;
		send_item(it);
	endtask

	task automatic send_sprite_row(input int idx, input int bits);
		item_t it;
		it = noise_item(KIND_WR_SPRITE);
		it.idx  = IDX_W'(idx);
		it.bits = COLUMNS'(bits);
		send_item(it);
	endtask

	task automatic send_bottom(input int pos);
		item_t it;
		it = noise_item(KIND_SET_POS);
		it.bottom = POS_W'(pos);
		send_item(it);
	endtask

	initial begin
		int counted;
		int unsigned roll;
		bit paused;
		logic [KIND_W-1:0] k;
		item_t it;

		sb = new();
		counted = 0;
		paused = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty frame, corner pixels, sprite edges, unknown kinds
		send_tick();
		send_pixel(KIND_WR_PIXEL, 0, 0, 1'b1);
		send_pixel(KIND_WR_PIXEL, COLUMNS - 1, ROWS - 1, 1'b1);
		send_pixel(KIND_TGL_PIXEL, COLUMNS - 1, 0, 1'b0);
		send_sprite_row(0, 'hFF);
		send_sprite_row(SPRITE_ROWS - 1, 'h81);
		send_bottom(ROWS + SPRITE_ROWS - 1);
		repeat (COLUMNS) send_tick();
		send_bottom(SPRITE_ROWS);
		send_tick();
		send_bottom(1);
		send_tick();
		send_bottom(ROWS + SPRITE_ROWS);
		send_tick();
		send_bottom((1 << POS_W) - 1);
		send_tick();
		for (int u = 0; u < 3; u++) begin
			send_item(noise_item(KIND_W'(FIRST_UNUSED_KIND + u)));
		end
		send_pixel(KIND_WR_PIXEL, 0, 0, 1'b0);
		send_pixel(KIND_TGL_PIXEL, 0, ROWS - 1, 1'b0);

		// Random mix; the count covers kinds the block acts on
		while (counted < RANDOM_ITEMS) begin
			steady <= (counted >= 200 && counted < 300);
			if (counted == 100) begin
				hold_req <= 1'b1;
			end
			// Drain all results before going on
			if (counted == 400 && !paused) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				@(posedge clk);
				while (sb.pending_scans.size() != 0) @(posedge clk);
			end
			roll = $urandom_range(99);
			if (roll < 36) begin
				k = KIND_TICK;
			end else if (roll < 56) begin
				k = KIND_WR_PIXEL;
			end else if (roll < 70) begin
				k = KIND_TGL_PIXEL;
			end else if (roll < 82) begin
				k = KIND_WR_SPRITE;
			end else if (roll < 95) begin
				k = KIND_SET_POS;
			end else begin
				k = FIRST_UNUSED_KIND + KIND_W'($urandom_range(2));
			end
			it = noise_item(k);
			// Favor positions that put part of the sprite on the matrix
			if (k == KIND_SET_POS && $urandom_range(3) != 0) begin
				it.bottom = POS_W'($urandom_range(ROWS + SPRITE_ROWS - 1, 1));
			end
			send_item(it);
			if (k < FIRST_UNUSED_KIND) begin
				counted++;
			end
		end

		// Let the last results drain
		in_valid <= 1'b0;
		while (sb.pending_scans.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
